>>> rtl/cpe_pkg.sv
// Shared types, constants and saturation helper for the complex polynomial evaluator.
package cpe_pkg;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;
    localparam int COEF_W    = 32;
    localparam int IDX_W     = 6;
    localparam int DEG_W     = 6;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_DEGREE = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_ACC,
        ST_FIN
    } cpe_state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] val;
        logic                     ovf;
    } sat_t;

    function automatic sat_t sat32(input logic signed [64:0] v);
        sat_t r;
        r.ovf = 1'b0;
        r.val = v[COEF_W-1:0];
        if (v > 65'sd2147483647) begin
            r.val = 32'sh7fffffff;
            r.ovf = 1'b1;
        end else if (v < -65'sd2147483648) begin
            r.val = 32'sh80000000;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> rtl/cpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/complex_polynomial_evaluator_unit.sv
// Top level: Horner evaluation of a complex Q15.16 polynomial on one shared complex MAC.
//
// A load item (tuser kind = 0) writes one complex coefficient into the coefficient RAM;
// slot 0 is the highest power, slots at or above MAX_TERMS are dropped. An
// evaluate item (kind = 1) runs z = z*x + c[j] over slots 0..min(degree, MAX_TERMS-1) and
// returns one item: real and imaginary parts saturated to 32 bits, plus a flag in tuser set
// if any step clipped. Each term passes the shared complex multiplier in order (multiply,
// shift/saturate of the products, coefficient add), so an evaluate holds s_tready low after
// acceptance until the sequencer is back in idle; the single multiply path serializes the
// terms. If the previous result still waits in the output register, the final state
// waits until m_tready takes it. A load leaves the input open. After reset the
// coefficient RAM is swept to zero, one entry per cycle; no item is accepted during that
// sweep, though degree may be written over APB. The finished result sits in an output
// register, so loads keep flowing while it waits on m_tready.
module complex_polynomial_evaluator_unit #(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpe_pkg::APB_AW-1:0]     paddr,
    input  logic [cpe_pkg::APB_DW-1:0]     pwdata,
    output logic [cpe_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [5:0] coef_index, [37:6] value_re, [69:38] value_im, [71:70] zero
    input  logic [cpe_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] kind
    input  logic [0:0]                     s_tuser,
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] result_re, [63:32] result_im
    output logic [cpe_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] saturated
    output logic [0:0]                     m_tuser
);

    import cpe_pkg::*;

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int LAST_MAX = MAX_TERMS - 1;

    // ---------------- input unpack ----------------
    logic                     in_kind;
    logic [IDX_W-1:0]         in_idx;
    logic signed [COEF_W-1:0] in_re;
    logic signed [COEF_W-1:0] in_im;
    logic                     in_fire;

    assign in_kind = s_tuser[0];
    assign in_idx  = s_tdata[5:0];
    assign in_re   = s_tdata[37:6];
    assign in_im   = s_tdata[69:38];

    // ---------------- config register ----------------
    logic [DEG_W-1:0] degree_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= '0;
        end else if (cfg_wr && (paddr[2] == REG_DEGREE)) begin
            degree_reg <= pwdata[DEG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEGREE) ? APB_DW'(degree_reg) : '0;

    // ---------------- state ----------------
    cpe_state_t state_reg, state_next;
    logic [AW-1:0] j_reg, j_next;        // term index, also clear sweep address
    logic [AW-1:0] last_reg, last_next;  // last term index of this evaluate
    logic          sat_reg, sat_next;
    logic          out_valid_reg, out_valid_next;

    logic signed [COEF_W-1:0] xr_reg, xi_reg, zr_reg, zi_reg, mr_reg, mi_reg;
    logic signed [63:0]       p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;
    logic                     out_sat_reg;

    // coefficient RAM
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [2*COEF_W-1:0]     ram_wdata;
    logic [2*COEF_W-1:0]     ram_rdata;

    cpe_ram #(
        .WIDTH (2*COEF_W),
        .DEPTH (MAX_TERMS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (j_reg),
        .rdata (ram_rdata)
    );

    // ---------------- shared complex MAC datapath ----------------
    logic signed [64:0] sum_r, sum_i, acc_r, acc_i;
    sat_t               m_r, m_i, z_r, z_i;
    logic [31:0]        deg_ext;
    logic [AW-1:0]      last_calc;
    logic               idx_ok;
    logic               start;
    logic               load_out;

    // floor shift of the exact product sums, then clip
    assign sum_r = (65'(p_rr_reg) - 65'(p_ii_reg)) >>> FRAC_BITS;
    assign sum_i = (65'(p_ri_reg) + 65'(p_ir_reg)) >>> FRAC_BITS;
    assign m_r   = sat32(sum_r);
    assign m_i   = sat32(sum_i);

    // coefficient add, re in the low half of the RAM word
    assign acc_r = 65'(mr_reg) + 65'(signed'(ram_rdata[COEF_W-1:0]));
    assign acc_i = 65'(mi_reg) + 65'(signed'(ram_rdata[2*COEF_W-1:COEF_W]));
    assign z_r   = sat32(acc_r);
    assign z_i   = sat32(acc_i);

    assign deg_ext   = 32'(degree_reg);
    assign last_calc = (deg_ext >= 32'(LAST_MAX)) ? AW'(LAST_MAX) : AW'(deg_ext);
    assign idx_ok    = 32'(in_idx) < 32'(MAX_TERMS);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        j_next         = j_reg;
        last_next      = last_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = j_reg;
        ram_wdata      = '0;
        start          = 1'b0;
        load_out       = 1'b0;

        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (j_reg == AW'(LAST_MAX)) begin
                    j_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_kind == KIND_LOAD) begin
                        ram_we    = idx_ok;
                        ram_waddr = AW'(in_idx);
                        ram_wdata = {in_im, in_re};
                    end else begin
                        start      = 1'b1;
                        j_next     = '0;
                        last_next  = last_calc;
                        sat_next   = 1'b0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sat_next   = sat_reg | m_r.ovf | m_i.ovf;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                sat_next = sat_reg | z_r.ovf | z_i.ovf;
                if (j_reg == last_reg) begin
                    state_next = ST_FIN;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready) begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            j_reg         <= '0;
            last_reg      <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            last_reg      <= last_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (start) begin
            xr_reg <= in_re;
            xi_reg <= in_im;
            zr_reg <= '0;
            zi_reg <= '0;
        end
        if (state_reg == ST_MUL) begin
            p_rr_reg <= zr_reg * xr_reg;
            p_ii_reg <= zi_reg * xi_reg;
            p_ri_reg <= zr_reg * xi_reg;
            p_ir_reg <= zi_reg * xr_reg;
        end
        if (state_reg == ST_SUM) begin
            mr_reg <= m_r.val;
            mi_reg <= m_i.val;
        end
        if (state_reg == ST_ACC) begin
            zr_reg <= z_r.val;
            zi_reg <= z_i.val;
        end
        if (load_out) begin
            out_data_reg <= {zi_reg, zr_reg};
            out_sat_reg  <= sat_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

endmodule

>>> rtl/cpe_checker.sv
// Port-level checks for the complex polynomial evaluator, bound to the top level.
module cpe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cpe_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    import cpe_pkg::*;

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // coefficient sweep keeps the input closed after reset
    a_clear_busy: assert property (@(posedge aclk) $rose(aresetn) |-> !s_tready)
        else $error("input ready during coefficient clear");

    // an evaluate item occupies the MAC, so the next cycle is busy
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == KIND_EVAL)) |=> !s_tready)
        else $error("ready right after evaluate item");

    // a new result is posted as the sequencer returns to idle
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result posted while still busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind complex_polynomial_evaluator_unit cpe_checker u_cpe_checker (.*);

>>> tb/tb_complex_polynomial_evaluator_unit.sv
// Self-checking testbench for the complex polynomial evaluator: APB degree, stream loads and evaluations.
module tb_complex_polynomial_evaluator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cpe_pkg::*;

    localparam int MAX_TERMS    = 64;
    localparam int FRAC_BITS    = 16;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    // extra settle time after the last expected result has been taken
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 1500;
    localparam int RANDOM_ITEMS  = 600;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        sat;
    } poly_value_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [5:0] coef_index, [37:6] value_re, [69:38] value_im, [71:70] zero
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // [0] kind
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [31:0] result_re, [63:32] result_im
    logic [M_TDATA_W-1:0]  m_tdata;
    // [0] saturated
    logic [0:0]            m_tuser;

    // predictor state: our own copy of the coefficient store and the degree register
    logic signed [31:0] stored_re [MAX_TERMS];
    logic signed [31:0] stored_im [MAX_TERMS];
    logic [DEG_W-1:0]   degree_setting;

    poly_value_t pending_values[$];

    int fail_count     = 0;
    int items_sent     = 0;
    int loads_sent     = 0;
    int evals_sent     = 0;
    int results_seen   = 0;
    int saturated_seen = 0;
    int degree_writes  = 0;
    int burst_left     = 0;
    bit hold_pending   = 1'b0;

    complex_polynomial_evaluator_unit #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Watchdog: a run that outlasts the timeout, with all its items, stalls, gaps, the long hold
    // and the clear sweep, is reported NOT OK and stopped.
    initial begin
        #20ms;
        $display("tb_complex_polynomial_evaluator_unit NOT OK");
        $finish;
    end

    // Clip to 32 bits signed; clipping sets the caller's flag.
    function automatic logic signed [31:0] clip32(input logic signed [65:0] v,
                                                  inout bit clipped);
        if (v > 66'sd2147483647) begin
            clipped = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -66'sd2147483648) begin
            clipped = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Horner over slots 0..degree at point x: z = z*x + c[j], Q15.16 with floor shift.
    function automatic poly_value_t horner_value(input logic signed [31:0] xr,
                                                 input logic signed [31:0] xi);
        logic signed [65:0] xr_w, xi_w, zr_w, zi_w, prod_re, prod_im, sum_w;
        logic signed [31:0] zr, zi, mr, mi;
        bit                 clipped;
        int                 terms;
        poly_value_t        v;
        xr_w    = xr;
        xi_w    = xi;
        zr      = '0;
        zi      = '0;
        clipped = 1'b0;
        terms   = int'(degree_setting) + 1;
        if (terms > MAX_TERMS) begin
            terms = MAX_TERMS;
        end
        for (int j = 0; j < terms; j++) begin
            zr_w    = zr;
            zi_w    = zi;
            // exact 66-bit sums, arithmetic shift rounds toward minus infinity
            prod_re = (zr_w * xr_w - zi_w * xi_w) >>> FRAC_BITS;
            prod_im = (zr_w * xi_w + zi_w * xr_w) >>> FRAC_BITS;
            mr      = clip32(prod_re, clipped);
            mi      = clip32(prod_im, clipped);
            sum_w   = mr;
            sum_w   = sum_w + stored_re[j];
            zr      = clip32(sum_w, clipped);
            sum_w   = mi;
            sum_w   = sum_w + stored_im[j];
            zi      = clip32(sum_w, clipped);
        end
        v.re  = zr;
        v.im  = zi;
        v.sat = clipped;
        return v;
    endfunction

    // Drive one item and hold it until accepted; the predictor runs on acceptance.
    // Bursts: between bursts valid drops for a random gap (sometimes none at all).
    task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic [31:0] re, input logic [31:0] im);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, im, re, idx};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (kind == KIND_LOAD) begin
            loads_sent++;
            if (int'(idx) < MAX_TERMS) begin
                stored_re[idx] = re;
                stored_im[idx] = im;
            end
        end else begin
            evals_sent++;
            pending_values.push_back(horner_value(re, im));
        end
    endtask

    task automatic load_coef(input int idx, input logic [31:0] re, input logic [31:0] im);
        send_item(KIND_LOAD, IDX_W'(idx), re, im);
    endtask

    task automatic evaluate_at(input logic [31:0] re, input logic [31:0] im);
        // coef_index is a don't-care on evaluate; keep it moving anyway
        send_item(KIND_EVAL, IDX_W'($urandom), re, im);
    endtask

    // Sender pause: stop offering, wait for every expected result, then let the block settle.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write of degree: setup cycle, then access until pready.
    task automatic write_degree(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DEGREE, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        degree_setting = DEG_W'(value);
        degree_writes++;
        @(posedge aclk);
    endtask

    // Random Q15.16 value: full range, small magnitudes up to 2.0, tiny, or an edge value.
    function automatic logic [31:0] random_q();
        logic [31:0] edges [6] = '{32'h7fffffff, 32'h80000000, 32'h00000000,
                                   32'hffffffff, 32'h00010000, 32'hffff0000};
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2, 3, 4: return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
            5, 6:    return 32'($signed($urandom_range(0, 32'h2000)) - 32'sh1000);
            default: return edges[$urandom_range(0, 5)];
        endcase
    endfunction

    // Points mostly inside the unit disk so that higher degrees do not all saturate.
    function automatic logic [31:0] random_point();
        if ($urandom_range(0, 4) == 0) begin
            return random_q();
        end
        return 32'($signed($urandom_range(0, 32'h16000)) - 32'shb000);
    endfunction

    // Right after reset, offered while the store is still being swept: nothing loaded reads as zero,
    // including at the largest degree.
    task automatic test_unloaded_store();
        write_degree(DEG_W'(MAX_TERMS - 1));
        evaluate_at(32'h00010000, 32'h00000000);
        evaluate_at(32'h80000000, 32'h7fffffff);
        wait_all_results();
        write_degree(0);
        evaluate_at(32'h7fffffff, 32'h80000000);
        wait_all_results();
    endtask

    // Field extremes, both kinds, saturation on multiply and on add, floor of negatives.
    task automatic test_directed_extremes();
        load_coef(0, 32'h7fffffff, 32'h80000000);
        load_coef(MAX_TERMS - 1, 32'h80000000, 32'h7fffffff);
        evaluate_at(32'h80000000, 32'h7fffffff);
        wait_all_results();

        write_degree(1);
        load_coef(1, 32'h7fffffff, 32'h7fffffff);
        evaluate_at(32'h7fffffff, 32'h80000000);
        evaluate_at(32'h00010000, 32'h00000000);
        evaluate_at(32'h00000000, 32'h00000000);
        evaluate_at(32'hffffffff, 32'hffffffff);
        load_coef(0, 32'hffff0000, 32'h00008000);
        load_coef(1, 32'h00000001, 32'hffffffff);
        evaluate_at(32'hffffffff, 32'h00000001);
        evaluate_at(32'hfffe8000, 32'h00013333);
        wait_all_results();

        write_degree(MAX_TERMS - 1);
        load_coef(32, 32'h00018000, 32'hfffe0000);
        evaluate_at(32'h00010000, 32'h00000000);
        evaluate_at(32'h00000000, 32'h00010000);
        evaluate_at(32'h80000000, 32'h80000000);
        evaluate_at(32'h00008000, 32'hffff8000);
        wait_all_results();
    endtask

    // Output held off for a long stretch while the sender keeps offering: the result
    // register fills and the input stalls behind it.
    task automatic test_output_backpressure();
        write_degree(4);
        hold_pending = 1'b1;
        for (int n = 0; n < 24; n++) begin
            if (n % 3 == 0) begin
                evaluate_at(random_point(), random_point());
            end else begin
                load_coef($urandom_range(0, 4), random_q(), random_q());
            end
        end
        wait_all_results();
    endtask

    // Phases at random degrees: mostly a full coefficient load followed by evaluations,
    // with stray loads and partly loaded polynomials mixed in.
    task automatic test_random_polynomials();
        int target;
        int deg;
        int n_evals;
        int start;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            wait_all_results();
            case ($urandom_range(0, 9))
                0:       deg = MAX_TERMS - 1;
                1:       deg = $urandom_range(8, MAX_TERMS - 2);
                default: deg = $urandom_range(0, 7);
            endcase
            write_degree(deg);
            if ($urandom_range(0, 3) != 0) begin
                // full polynomial, ascending or from a random starting slot
                start = $urandom_range(0, deg);
                for (int k = 0; k <= deg; k++) begin
                    load_coef((start + k) % (deg + 1), random_q(), random_q());
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    load_coef($urandom_range(0, MAX_TERMS - 1), random_q(), random_q());
                end
            end
            n_evals = $urandom_range(1, 6);
            repeat (n_evals) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        load_coef($urandom_range(0, MAX_TERMS - 1), random_q(), random_q());
                    end
                end
                evaluate_at(random_point(), random_point());
            end
        end
    endtask

    // Receiver: switches among stall patterns on its own; a requested long hold is
    // counted here, cycle by cycle.
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_pending && hold_left == 0) begin
                hold_left    = LONG_HOLD;
                hold_pending = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 400);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge aclk) begin : check_results
        poly_value_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[0]) begin
                saturated_seen++;
            end
            if (pending_values.size() == 0) begin
                $error("result item with nothing expected: re %h im %h sat %b",
                       m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
                fail_count++;
            end else begin
                want = pending_values.pop_front();
                if (m_tdata[31:0] !== want.re) begin
                    $error("result_re mismatch: expected %h, got %h", want.re, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.im) begin
                    $error("result_im mismatch: expected %h, got %h", want.im, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tuser[0] !== want.sat) begin
                    $error("saturated mismatch: expected %b, got %b", want.sat, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < MAX_TERMS; k++) begin
            stored_re[k] = '0;
            stored_im[k] = '0;
        end
        degree_setting = '0;
        // synchronous reset, released once and never asserted again
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_unloaded_store();
        test_directed_extremes();
        test_output_backpressure();
        test_random_polynomials();
        wait_all_results();

        if (pending_values.size() != 0) begin
            $error("%0d expected results never arrived", pending_values.size());
            fail_count++;
        end
        $display("Covered %0d items (%0d loads, %0d evaluations) over %0d degree settings;",
                 items_sent, loads_sent, evals_sent, degree_writes);
        $display("checked %0d results, %0d of them saturated, with one long output hold.",
                 results_seen, saturated_seen);
        if (fail_count == 0) begin
            $display("tb_complex_polynomial_evaluator_unit OK");
        end else begin
            $display("tb_complex_polynomial_evaluator_unit NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/cpe_pkg.sv
rtl/cpe_ram.sv
rtl/complex_polynomial_evaluator_unit.sv
rtl/cpe_checker.sv
tb/tb_complex_polynomial_evaluator_unit.sv
